[rtl/bci_pkg.sv]
package bci_pkg;

	localparam int unsigned STACK_DEPTH_DEF = 1024;
	localparam int unsigned LOCAL_COUNT_DEF = 256;
	localparam int unsigned DEPTH_W = 11;
	localparam int unsigned CNT_W = 3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_UNSUP = 2'd1;
	localparam logic [1:0] ST_FAULT = 2'd2;
	localparam logic [1:0] ST_DIVZ = 2'd3;

	localparam logic [2:0] COND_EQ = 3'd0;
	localparam logic [2:0] COND_NE = 3'd1;
	localparam logic [2:0] COND_LT = 3'd2;
	localparam logic [2:0] COND_GE = 3'd3;
	localparam logic [2:0] COND_GT = 3'd4;

	localparam logic [7:0] OP_NOP = 8'd0;
	localparam logic [7:0] OP_ACONST_NULL = 8'd1;
	localparam logic [7:0] OP_ICONST_M1 = 8'd2;
	localparam logic [7:0] OP_ICONST_5 = 8'd8;
	localparam logic [7:0] OP_LCONST_0 = 8'd9;
	localparam logic [7:0] OP_LCONST_1 = 8'd10;
	localparam logic [7:0] OP_BIPUSH = 8'd16;
	localparam logic [7:0] OP_SIPUSH = 8'd17;
	localparam logic [7:0] OP_LDC = 8'd18;
	localparam logic [7:0] OP_LDC_W = 8'd19;
	localparam logic [7:0] OP_ILOAD = 8'd21;
	localparam logic [7:0] OP_LLOAD = 8'd22;
	localparam logic [7:0] OP_FLOAD = 8'd23;
	localparam logic [7:0] OP_DLOAD = 8'd24;
	localparam logic [7:0] OP_ALOAD = 8'd25;
	localparam logic [7:0] OP_ILOAD_0 = 8'd26;
	localparam logic [7:0] OP_ALOAD_3 = 8'd45;
	localparam logic [7:0] OP_ISTORE = 8'd54;
	localparam logic [7:0] OP_LSTORE = 8'd55;
	localparam logic [7:0] OP_FSTORE = 8'd56;
	localparam logic [7:0] OP_DSTORE = 8'd57;
	localparam logic [7:0] OP_ASTORE = 8'd58;
	localparam logic [7:0] OP_ISTORE_0 = 8'd59;
	localparam logic [7:0] OP_ASTORE_3 = 8'd78;
	localparam logic [7:0] OP_POP = 8'd87;
	localparam logic [7:0] OP_POP2 = 8'd88;
	localparam logic [7:0] OP_DUP = 8'd89;
	localparam logic [7:0] OP_DUP_X1 = 8'd90;
	localparam logic [7:0] OP_DUP_X2 = 8'd91;
	localparam logic [7:0] OP_DUP2 = 8'd92;
	localparam logic [7:0] OP_DUP2_X1 = 8'd93;
	localparam logic [7:0] OP_DUP2_X2 = 8'd94;
	localparam logic [7:0] OP_SWAP = 8'd95;
	localparam logic [7:0] OP_IADD = 8'd96;
	localparam logic [7:0] OP_ISUB = 8'd100;
	localparam logic [7:0] OP_IMUL = 8'd104;
	localparam logic [7:0] OP_IDIV = 8'd108;
	localparam logic [7:0] OP_IREM = 8'd112;
	localparam logic [7:0] OP_INEG = 8'd116;
	localparam logic [7:0] OP_ISHL = 8'd120;
	localparam logic [7:0] OP_ISHR = 8'd122;
	localparam logic [7:0] OP_IUSHR = 8'd124;
	localparam logic [7:0] OP_IAND = 8'd126;
	localparam logic [7:0] OP_LAND = 8'd127;
	localparam logic [7:0] OP_IOR = 8'd128;
	localparam logic [7:0] OP_LOR = 8'd129;
	localparam logic [7:0] OP_IXOR = 8'd130;
	localparam logic [7:0] OP_LXOR = 8'd131;
	localparam logic [7:0] OP_IINC = 8'd132;
	localparam logic [7:0] OP_I2L = 8'd133;
	localparam logic [7:0] OP_L2I = 8'd136;
	localparam logic [7:0] OP_I2B = 8'd145;
	localparam logic [7:0] OP_I2C = 8'd146;
	localparam logic [7:0] OP_I2S = 8'd147;
	localparam logic [7:0] OP_IFEQ = 8'd153;
	localparam logic [7:0] OP_IFLE = 8'd158;
	localparam logic [7:0] OP_IF_ICMPEQ = 8'd159;
	localparam logic [7:0] OP_IF_ICMPLE = 8'd164;
	localparam logic [7:0] OP_IF_ACMPEQ = 8'd165;
	localparam logic [7:0] OP_IF_ACMPNE = 8'd166;
	localparam logic [7:0] OP_GOTO = 8'd167;
	localparam logic [7:0] OP_JSR = 8'd168;
	localparam logic [7:0] OP_RET = 8'd169;
	localparam logic [7:0] OP_WIDE = 8'd196;
	localparam logic [7:0] OP_IFNULL = 8'd198;
	localparam logic [7:0] OP_IFNONNULL = 8'd199;
	localparam logic [7:0] OP_GOTO_W = 8'd200;
	localparam logic [7:0] OP_JSR_W = 8'd201;

	typedef struct packed {
		logic [7:0] operation;
		logic signed [31:0] immediate;
		logic signed [7:0] increment;
		logic [15:0] instr_addr;
	} instr_t;

	typedef struct packed {
		logic [15:0] next_addr;
		logic signed [31:0] top_value;
		logic [DEPTH_W-1:0] depth;
		logic [1:0] status;
	} result_t;

	typedef struct packed {
		logic sup;
		logic [2:0] rd;
		logic [1:0] grow;
		logic signed [3:0] dlt;
		logic [2:0] nw;
		logic [1:0] nl;
		logic [1:0] nlw;
		logic [2:0] len;
		logic lfix;
		logic [1:0] lbase;
	} dec_t;

	typedef struct packed {
		logic load;
		logic rd_en;
		logic [CNT_W-1:0] rd_cnt;
		logic ex;
		logic div_start;
		logic wr_en;
		logic [CNT_W-1:0] wr_cnt;
		logic commit;
		logic top_rd;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic pre_fault;
		logic [CNT_W-1:0] nrd;
		logic [CNT_W-1:0] nwr;
		logic is_div;
		logic divz;
		logic div_done;
		logic ok;
	} stat_t;

	function automatic logic cond_holds(input logic [2:0] kind, input logic [31:0] a,
			input logic [31:0] b);
		logic lt;
		logic gt;
		lt = $signed(a) < $signed(b);
		gt = $signed(b) < $signed(a);
		case (kind)
			COND_EQ: cond_holds = (a == b);
			COND_NE: cond_holds = (a != b);
			COND_LT: cond_holds = lt;
			COND_GE: cond_holds = !lt;
			COND_GT: cond_holds = gt;
			default: cond_holds = !gt;
		endcase
	endfunction

	function automatic dec_t decode(input logic [7:0] op);
		dec_t d;
		logic [7:0] sub;
		d = '0;
		d.sup = 1'b1;
		d.len = 3'd1;
		sub = '0;
		case (op) inside
			OP_NOP: ;
			OP_ACONST_NULL, [OP_ICONST_M1:OP_ICONST_5]: begin
				d.grow = 2'd1; d.dlt = 4'sd1; d.nw = 3'd1;
			end
			OP_LCONST_0, OP_LCONST_1: begin
				d.grow = 2'd2; d.dlt = 4'sd2; d.nw = 3'd2;
			end
			OP_BIPUSH, OP_LDC: begin
				d.grow = 2'd1; d.dlt = 4'sd1; d.nw = 3'd1; d.len = 3'd2;
			end
			OP_SIPUSH, OP_LDC_W: begin
				d.grow = 2'd1; d.dlt = 4'sd1; d.nw = 3'd1; d.len = 3'd3;
			end
			OP_ILOAD, OP_FLOAD, OP_ALOAD: begin
				d.grow = 2'd1; d.dlt = 4'sd1; d.nw = 3'd1; d.nl = 2'd1; d.len = 3'd2;
			end
			OP_LLOAD, OP_DLOAD: begin
				d.grow = 2'd2; d.dlt = 4'sd2; d.nw = 3'd2; d.nl = 2'd2; d.len = 3'd2;
			end
			[OP_ILOAD_0:OP_ALOAD_3]: begin
				sub = op - OP_ILOAD_0;
				d.lfix = 1'b1;
				d.lbase = sub[1:0];
				if (sub[2]) begin
					d.grow = 2'd2; d.dlt = 4'sd2; d.nw = 3'd2; d.nl = 2'd2;
				end else begin
					d.grow = 2'd1; d.dlt = 4'sd1; d.nw = 3'd1; d.nl = 2'd1;
				end
			end
			OP_ISTORE, OP_FSTORE, OP_ASTORE: begin
				d.rd = 3'd1; d.dlt = -4'sd1; d.nlw = 2'd1; d.len = 3'd2;
			end
			OP_LSTORE, OP_DSTORE: begin
				d.rd = 3'd2; d.dlt = -4'sd2; d.nlw = 2'd2; d.len = 3'd2;
			end
			[OP_ISTORE_0:OP_ASTORE_3]: begin
				sub = op - OP_ISTORE_0;
				d.lfix = 1'b1;
				d.lbase = sub[1:0];
				if (sub[2]) begin
					d.rd = 3'd2; d.dlt = -4'sd2; d.nlw = 2'd2;
				end else begin
					d.rd = 3'd1; d.dlt = -4'sd1; d.nlw = 2'd1;
				end
			end
			OP_POP: begin
				d.rd = 3'd1; d.dlt = -4'sd1;
			end
			OP_POP2: begin
				d.rd = 3'd2; d.dlt = -4'sd2;
			end
			OP_DUP: begin
				d.rd = 3'd1; d.grow = 2'd1; d.dlt = 4'sd1; d.nw = 3'd1;
			end
			OP_DUP_X1: begin
				d.rd = 3'd2; d.grow = 2'd1; d.dlt = 4'sd1; d.nw = 3'd3;
			end
			OP_DUP_X2: begin
				d.rd = 3'd3; d.grow = 2'd1; d.dlt = 4'sd1; d.nw = 3'd4;
			end
			OP_DUP2: begin
				d.rd = 3'd2; d.grow = 2'd2; d.dlt = 4'sd2; d.nw = 3'd2;
			end
			OP_DUP2_X1: begin
				d.rd = 3'd3; d.grow = 2'd2; d.dlt = 4'sd2; d.nw = 3'd5;
			end
			OP_DUP2_X2: begin
				d.rd = 3'd4; d.grow = 2'd2; d.dlt = 4'sd2; d.nw = 3'd6;
			end
			OP_SWAP: begin
				d.rd = 3'd2; d.nw = 3'd2;
			end
			OP_IADD, OP_ISUB, OP_IMUL, OP_IDIV, OP_IREM, OP_ISHL, OP_ISHR, OP_IUSHR,
			OP_IAND, OP_IOR, OP_IXOR: begin
				d.rd = 3'd2; d.dlt = -4'sd1; d.nw = 3'd1;
			end
			OP_INEG, OP_I2B, OP_I2C, OP_I2S: begin
				d.rd = 3'd1; d.nw = 3'd1;
			end
			OP_LAND, OP_LOR, OP_LXOR: begin
				d.rd = 3'd4; d.dlt = -4'sd2; d.nw = 3'd2;
			end
			OP_IINC: begin
				d.nl = 2'd1; d.nlw = 2'd1; d.len = 3'd3;
			end
			OP_I2L: begin
				d.rd = 3'd1; d.grow = 2'd1; d.dlt = 4'sd1; d.nw = 3'd1;
			end
			OP_L2I: begin
				d.rd = 3'd2; d.dlt = -4'sd1;
			end
			[OP_IFEQ:OP_IFLE], OP_IFNULL, OP_IFNONNULL: begin
				d.rd = 3'd1; d.dlt = -4'sd1; d.len = 3'd3;
			end
			[OP_IF_ICMPEQ:OP_IF_ACMPNE]: begin
				d.rd = 3'd2; d.dlt = -4'sd2; d.len = 3'd3;
			end
			OP_GOTO: d.len = 3'd3;
			OP_GOTO_W: d.len = 3'd5;
			OP_JSR: begin
				d.grow = 2'd1; d.dlt = 4'sd1; d.nw = 3'd1; d.len = 3'd3;
			end
			OP_JSR_W: begin
				d.grow = 2'd1; d.dlt = 4'sd1; d.nw = 3'd1; d.len = 3'd5;
			end
			OP_RET: begin
				d.nl = 2'd1; d.len = 3'd2;
			end
			OP_WIDE: d.len = 3'd2;
			default: d.sup = 1'b0;
		endcase
		return d;
	endfunction

endpackage

[rtl/bci_if.sv]
interface bci_in_if;
	logic valid;
	logic ready;
	bci_pkg::instr_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface bci_out_if;
	logic valid;
	logic ready;
	bci_pkg::result_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

[rtl/stack_bytecode_integer_core.sv]
// Integer stack-machine core: takes one decoded bytecode per request and returns one
// result with the next code address, the new top of stack, the stack depth and a status.
// Operand stack and locals sit in single-write, single-read memories, so each memory moves
// the words that an instruction reads or writes one at a time: it reads up to 4 stack words
// and 2 locals and writes up to 6 stack words and 2 locals, and idiv and irem also run the
// bit-serial divider. An unsupported request, or one that fails its stack or local index
// check, skips execution and writes nothing; a divide by zero writes nothing either. A
// finished result is held in an output register while the next request is taken; a request
// waits in its last state for as long as the previous result has not been taken. Locals
// and stack contents are not cleared by reset.
module stack_bytecode_integer_core #(
	parameter int unsigned STACK_DEPTH = bci_pkg::STACK_DEPTH_DEF,
	parameter int unsigned LOCAL_COUNT = bci_pkg::LOCAL_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	bci_in_if.sink instr,
	bci_out_if.source result
);

	bci_pkg::cmd_t ctl_cmd;
	bci_pkg::stat_t dp_stat;

	bci_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(instr.valid),
		.in_ready(instr.ready),
		.out_valid(result.valid),
		.out_ready(result.ready),
		.stat(dp_stat),
		.cmd(ctl_cmd)
	);

	bci_dp #(
		.STACK_DEPTH(STACK_DEPTH),
		.LOCAL_COUNT(LOCAL_COUNT)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.instr_data(instr.data),
		.cmd(ctl_cmd),
		.stat(dp_stat),
		.res_data(result.data)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		instr.valid && instr.ready |=> !instr.ready)
		else $error("request accepted while another is in flight");

	a_no_write_on_fault: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_cmd.wr_en |-> dp_stat.ok)
		else $error("state written by a faulted request");

	a_div_guard: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_cmd.div_start |-> dp_stat.is_div && !dp_stat.divz)
		else $error("divider started without a nonzero divisor");

endmodule

[rtl/bci_div.sv]
module bci_div (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [31:0] dividend,
	input logic [31:0] divisor,
	output logic done,
	output logic [31:0] quo,
	output logic [31:0] rem
);

	logic busy_q;
	logic done_q;
	logic [4:0] cnt_q;
	logic [31:0] r_q;
	logic [31:0] q_q;
	logic [31:0] d_q;
	logic nq_q;
	logic nr_q;
	logic [32:0] sh;
	logic [32:0] diff;

	assign sh = {r_q, q_q[31]};
	assign diff = sh - {1'b0, d_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend[31] ? 32'd0 - dividend : dividend;
			d_q <= divisor[31] ? 32'd0 - divisor : divisor;
			r_q <= '0;
			nq_q <= dividend[31] ^ divisor[31];
			nr_q <= dividend[31];
		end else if (busy_q) begin
			if (!diff[32]) begin
				r_q <= diff[31:0];
				q_q <= {q_q[30:0], 1'b1};
			end else begin
				r_q <= sh[31:0];
				q_q <= {q_q[30:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo = nq_q ? 32'd0 - q_q : q_q;
	assign rem = nr_q ? 32'd0 - r_q : r_q;

endmodule

[rtl/bci_dp.sv]
module bci_dp #(
	parameter int unsigned STACK_DEPTH = bci_pkg::STACK_DEPTH_DEF,
	parameter int unsigned LOCAL_COUNT = bci_pkg::LOCAL_COUNT_DEF
) (
	input logic clk,
	input logic arst_n,
	input bci_pkg::instr_t instr_data,
	input bci_pkg::cmd_t cmd,
	output bci_pkg::stat_t stat,
	output bci_pkg::result_t res_data
);

	localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);
	localparam int unsigned SAW = $clog2(STACK_DEPTH);
	localparam int unsigned LAW = $clog2(LOCAL_COUNT);
	localparam int unsigned DW = bci_pkg::DEPTH_W;
	localparam int unsigned CW = bci_pkg::CNT_W;

	logic [31:0] stk_mem [STACK_DEPTH];
	logic [31:0] loc_mem [LOCAL_COUNT];

	bci_pkg::instr_t ins_q;
	bci_pkg::result_t res_q;
	bci_pkg::dec_t dec;
	logic [SPW-1:0] sp_q;
	logic [7:0] whb_q;
	logic [1:0] st_q;
	logic [31:0] w_q [4];
	logic [31:0] loc_q [2];
	logic [31:0] v_q [6];
	logic [31:0] lv_q [2];
	logic [15:0] na_q;
	logic [31:0] srd_q;
	logic [31:0] lrd_q;

	logic [7:0] op;
	logic [31:0] imm;
	logic [15:0] pc;
	logic [15:0] idx;
	logic [1:0] nchk;
	logic loc_ok;
	logic sp_ok;
	logic [1:0] pre_st;
	logic [SPW-1:0] sp_new;
	logic [16:0] lbase;
	logic [16:0] lra_full;
	logic [16:0] lwa_full;
	logic [SPW-1:0] sra_full;
	logic [SPW-1:0] swa_full;
	logic s_re;
	logic s_we;
	logic l_re;
	logic l_we;
	logic [CW-1:0] cap_k;
	logic ex_jump;
	logic [15:0] ex_target;
	logic is_div;
	logic div_done;
	logic [31:0] div_quo;
	logic [31:0] div_rem;

	assign op = ins_q.operation;
	assign imm = ins_q.immediate;
	assign pc = ins_q.instr_addr;
	assign dec = bci_pkg::decode(op);
	assign idx = {whb_q, imm[7:0]};
	assign nchk = (dec.nl > dec.nlw) ? dec.nl : dec.nlw;
	assign loc_ok = dec.lfix || (nchk == 2'd0)
		|| (({1'b0, idx} + 17'(nchk)) <= 17'(LOCAL_COUNT));
	assign sp_ok = (sp_q >= SPW'(dec.rd))
		&& (({1'b0, sp_q} + (SPW + 1)'(dec.grow)) <= (SPW + 1)'(STACK_DEPTH));
	assign pre_st = !dec.sup ? bci_pkg::ST_UNSUP
		: ((loc_ok && sp_ok) ? bci_pkg::ST_OK : bci_pkg::ST_FAULT);
	assign sp_new = sp_q + SPW'(dec.dlt);
	assign is_div = (op == bci_pkg::OP_IDIV) || (op == bci_pkg::OP_IREM);

	assign lbase = dec.lfix ? {15'd0, dec.lbase} : {1'b0, idx};
	assign lra_full = lbase + 17'(cmd.rd_cnt);
	assign lwa_full = lbase + 17'(cmd.wr_cnt);
	assign sra_full = sp_q - SPW'(1) - (cmd.top_rd ? SPW'(0) : SPW'(cmd.rd_cnt));
	assign swa_full = sp_new - SPW'(1) - SPW'(cmd.wr_cnt);
	assign s_re = cmd.top_rd || (cmd.rd_en && (cmd.rd_cnt < CW'(dec.rd)));
	assign l_re = cmd.rd_en && (cmd.rd_cnt < CW'(dec.nl));
	assign s_we = cmd.wr_en && (cmd.wr_cnt < dec.nw);
	assign l_we = cmd.wr_en && (cmd.wr_cnt < CW'(dec.nlw));
	assign cap_k = cmd.rd_cnt - CW'(1);

	always_ff @(posedge clk) begin
		if (s_we) begin
			stk_mem[swa_full[SAW-1:0]] <= v_q[cmd.wr_cnt];
		end
		if (s_re) begin
			srd_q <= stk_mem[sra_full[SAW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (l_we) begin
			loc_mem[lwa_full[LAW-1:0]] <= lv_q[cmd.wr_cnt[0]];
		end
		if (l_re) begin
			lrd_q <= loc_mem[lra_full[LAW-1:0]];
		end
	end

	bci_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.div_start),
		.dividend(w_q[1]),
		.divisor(w_q[0]),
		.done(div_done),
		.quo(div_quo),
		.rem(div_rem)
	);

	always_comb begin
		ex_jump = 1'b0;
		ex_target = pc + imm[15:0];
		case (op) inside
			[bci_pkg::OP_IFEQ:bci_pkg::OP_IFLE]: begin
				ex_jump = bci_pkg::cond_holds(3'(op - bci_pkg::OP_IFEQ), w_q[0], 32'd0);
			end
			[bci_pkg::OP_IF_ICMPEQ:bci_pkg::OP_IF_ICMPLE]: begin
				ex_jump = bci_pkg::cond_holds(3'(op - bci_pkg::OP_IF_ICMPEQ), w_q[1], w_q[0]);
			end
			bci_pkg::OP_IF_ACMPEQ: ex_jump = (w_q[1] == w_q[0]);
			bci_pkg::OP_IF_ACMPNE: ex_jump = (w_q[1] != w_q[0]);
			bci_pkg::OP_IFNULL: ex_jump = (w_q[0] == 32'd0);
			bci_pkg::OP_IFNONNULL: ex_jump = (w_q[0] != 32'd0);
			bci_pkg::OP_GOTO, bci_pkg::OP_GOTO_W, bci_pkg::OP_JSR, bci_pkg::OP_JSR_W: begin
				ex_jump = 1'b1;
			end
			bci_pkg::OP_RET: begin
				ex_jump = 1'b1;
				ex_target = loc_q[0][15:0];
			end
			default: ex_jump = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
			whb_q <= '0;
			st_q <= bci_pkg::ST_OK;
		end else begin
			if (cmd.load) begin
				st_q <= bci_pkg::ST_OK;
			end else if (cmd.rd_en && (cmd.rd_cnt == '0)) begin
				st_q <= pre_st;
			end else if (cmd.ex && is_div && (w_q[0] == 32'd0)) begin
				st_q <= bci_pkg::ST_DIVZ;
			end
			if (cmd.commit && (st_q == bci_pkg::ST_OK)) begin
				sp_q <= sp_new;
				whb_q <= (op == bci_pkg::OP_WIDE) ? imm[7:0] : 8'd0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ins_q <= instr_data;
		end
		if (cmd.rd_en && (cmd.rd_cnt != '0)) begin
			w_q[cap_k[1:0]] <= srd_q;
			if (cap_k < CW'(2)) begin
				loc_q[cap_k[0]] <= lrd_q;
			end
		end
		if (cmd.ex) begin
			na_q <= ex_jump ? ex_target : pc + 16'(dec.len);
			case (op) inside
				bci_pkg::OP_ACONST_NULL: v_q[0] <= '0;
				[bci_pkg::OP_ICONST_M1:bci_pkg::OP_ICONST_5]: begin
					v_q[0] <= {24'd0, op} - 32'd3;
				end
				bci_pkg::OP_LCONST_0, bci_pkg::OP_LCONST_1: begin
					v_q[0] <= '0;
					v_q[1] <= {31'd0, op == bci_pkg::OP_LCONST_1};
				end
				bci_pkg::OP_BIPUSH: v_q[0] <= {{24{imm[7]}}, imm[7:0]};
				bci_pkg::OP_SIPUSH: v_q[0] <= {{16{imm[15]}}, imm[15:0]};
				bci_pkg::OP_LDC, bci_pkg::OP_LDC_W: v_q[0] <= imm;
				bci_pkg::OP_ILOAD, bci_pkg::OP_FLOAD, bci_pkg::OP_ALOAD,
				bci_pkg::OP_LLOAD, bci_pkg::OP_DLOAD,
				[bci_pkg::OP_ILOAD_0:bci_pkg::OP_ALOAD_3]: begin
					if (dec.nl == 2'd2) begin
						v_q[0] <= loc_q[1];
						v_q[1] <= loc_q[0];
					end else begin
						v_q[0] <= loc_q[0];
					end
				end
				bci_pkg::OP_ISTORE, bci_pkg::OP_FSTORE, bci_pkg::OP_ASTORE,
				bci_pkg::OP_LSTORE, bci_pkg::OP_DSTORE,
				[bci_pkg::OP_ISTORE_0:bci_pkg::OP_ASTORE_3]: begin
					lv_q[0] <= (dec.nlw == 2'd2) ? w_q[1] : w_q[0];
					lv_q[1] <= w_q[0];
				end
				bci_pkg::OP_DUP: v_q[0] <= w_q[0];
				bci_pkg::OP_DUP_X1: begin
					v_q[0] <= w_q[0]; v_q[1] <= w_q[1]; v_q[2] <= w_q[0];
				end
				bci_pkg::OP_DUP_X2: begin
					v_q[0] <= w_q[0]; v_q[1] <= w_q[1]; v_q[2] <= w_q[2]; v_q[3] <= w_q[0];
				end
				bci_pkg::OP_DUP2: begin
					v_q[0] <= w_q[0]; v_q[1] <= w_q[1];
				end
				bci_pkg::OP_DUP2_X1: begin
					v_q[0] <= w_q[0]; v_q[1] <= w_q[1]; v_q[2] <= w_q[2];
					v_q[3] <= w_q[0]; v_q[4] <= w_q[1];
				end
				bci_pkg::OP_DUP2_X2: begin
					v_q[0] <= w_q[0]; v_q[1] <= w_q[1]; v_q[2] <= w_q[2];
					v_q[3] <= w_q[3]; v_q[4] <= w_q[0]; v_q[5] <= w_q[1];
				end
				bci_pkg::OP_SWAP: begin
					v_q[0] <= w_q[1]; v_q[1] <= w_q[0];
				end
				bci_pkg::OP_IADD: v_q[0] <= w_q[1] + w_q[0];
				bci_pkg::OP_ISUB: v_q[0] <= w_q[1] - w_q[0];
				bci_pkg::OP_IMUL: v_q[0] <= w_q[1] * w_q[0];
				bci_pkg::OP_ISHL: v_q[0] <= w_q[1] << w_q[0][4:0];
				bci_pkg::OP_ISHR: v_q[0] <= 32'($signed(w_q[1]) >>> w_q[0][4:0]);
				bci_pkg::OP_IUSHR: v_q[0] <= w_q[1] >> w_q[0][4:0];
				bci_pkg::OP_IAND: v_q[0] <= w_q[1] & w_q[0];
				bci_pkg::OP_IOR: v_q[0] <= w_q[1] | w_q[0];
				bci_pkg::OP_IXOR: v_q[0] <= w_q[1] ^ w_q[0];
				bci_pkg::OP_INEG: v_q[0] <= 32'd0 - w_q[0];
				bci_pkg::OP_LAND: begin
					v_q[0] <= w_q[2] & w_q[0]; v_q[1] <= w_q[3] & w_q[1];
				end
				bci_pkg::OP_LOR: begin
					v_q[0] <= w_q[2] | w_q[0]; v_q[1] <= w_q[3] | w_q[1];
				end
				bci_pkg::OP_LXOR: begin
					v_q[0] <= w_q[2] ^ w_q[0]; v_q[1] <= w_q[3] ^ w_q[1];
				end
				bci_pkg::OP_IINC: begin
					lv_q[0] <= loc_q[0] + {{24{ins_q.increment[7]}}, ins_q.increment};
				end
				bci_pkg::OP_I2L: v_q[0] <= {32{w_q[0][31]}};
				bci_pkg::OP_I2B: v_q[0] <= {{24{w_q[0][7]}}, w_q[0][7:0]};
				bci_pkg::OP_I2C: v_q[0] <= {16'd0, w_q[0][15:0]};
				bci_pkg::OP_I2S: v_q[0] <= {{16{w_q[0][15]}}, w_q[0][15:0]};
				bci_pkg::OP_JSR: v_q[0] <= {16'd0, pc + 16'd3};
				bci_pkg::OP_JSR_W: v_q[0] <= {16'd0, pc + 16'd5};
				default: ;
			endcase
		end
		if (div_done) begin
			v_q[0] <= (op == bci_pkg::OP_IREM) ? div_rem : div_quo;
		end
		if (cmd.out_load) begin
			res_q.next_addr <= (st_q != bci_pkg::ST_OK) ? pc : na_q;
			res_q.top_value <= (sp_q == '0) ? 32'd0 : srd_q;
			res_q.depth <= DW'(sp_q);
			res_q.status <= st_q;
		end
	end

	assign stat.pre_fault = (pre_st != bci_pkg::ST_OK);
	assign stat.nrd = (CW'(dec.rd) > CW'(dec.nl)) ? CW'(dec.rd) : CW'(dec.nl);
	assign stat.nwr = (dec.nw > CW'(dec.nlw)) ? dec.nw : CW'(dec.nlw);
	assign stat.is_div = is_div;
	assign stat.divz = (w_q[0] == 32'd0);
	assign stat.div_done = div_done;
	assign stat.ok = (st_q == bci_pkg::ST_OK);
	assign res_data = res_q;

endmodule

[rtl/bci_ctrl.sv]
module bci_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input logic out_ready,
	input bci_pkg::stat_t stat,
	output bci_pkg::cmd_t cmd
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RD = 3'd1;
	localparam logic [2:0] S_EX = 3'd2;
	localparam logic [2:0] S_DIV = 3'd3;
	localparam logic [2:0] S_WR = 3'd4;
	localparam logic [2:0] S_TOP = 3'd5;
	localparam logic [2:0] S_TOPW = 3'd6;

	localparam int unsigned CW = bci_pkg::CNT_W;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cnt_d;
	logic out_valid_q;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		cnt_d = cnt_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_RD;
					cnt_d = '0;
				end
			end
			S_RD: begin
				cmd.rd_en = 1'b1;
				cmd.rd_cnt = cnt_q;
				if ((cnt_q == '0) && stat.pre_fault) begin
					state_d = S_TOP;
				end else if (cnt_q == stat.nrd) begin
					state_d = S_EX;
				end else begin
					cnt_d = cnt_q + CW'(1);
				end
			end
			S_EX: begin
				cmd.ex = 1'b1;
				cnt_d = '0;
				if (stat.is_div && !stat.divz) begin
					cmd.div_start = 1'b1;
					state_d = S_DIV;
				end else begin
					state_d = S_WR;
				end
			end
			S_DIV: begin
				if (stat.div_done) begin
					state_d = S_WR;
				end
			end
			S_WR: begin
				if (!stat.ok || (cnt_q == stat.nwr)) begin
					cmd.commit = 1'b1;
					state_d = S_TOP;
				end else begin
					cmd.wr_en = 1'b1;
					cmd.wr_cnt = cnt_q;
					cnt_d = cnt_q + CW'(1);
				end
			end
			S_TOP: begin
				cmd.top_rd = 1'b1;
				state_d = S_TOPW;
			end
			S_TOPW: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[tb/sv/stack_bytecode_integer_core_test.sv]
`timescale 1ns / 1ps

module stack_bytecode_integer_core_test;
	import bci_pkg::*;

	localparam int unsigned NSTK = STACK_DEPTH_DEF;
	localparam int unsigned NLOC = LOCAL_COUNT_DEF;
	localparam int RANDOM_ITEMS = 220;
	localparam longint CYCLE_LIMIT = 1500000;
	localparam logic [7:0] OP_UNSUP = 8'd255;

	class bytecode_scoreboard;
		logic [31:0] stk[NSTK];
		int unsigned sp;
		logic [31:0] loc[NLOC];
		bit loc_set[NLOC];
		int unsigned wide_hi;
		result_t pending[$];
		int errors;
		int results;
		int requests;
		int st_count[4];

		function bit fits(int unsigned rd, int unsigned grow);
			return sp >= rd && NSTK - sp >= grow;
		endfunction

		function logic [31:0] peek(int unsigned i);
			return (i < sp) ? stk[sp - 1 - i] : 32'd0;
		endfunction

		function void poke(int unsigned i, logic [31:0] v);
			if (i < sp) stk[sp - 1 - i] = v;
		endfunction

		function void push(logic [31:0] v);
			if (sp < NSTK) begin
				stk[sp] = v;
				sp++;
			end
		endfunction

		function logic [31:0] pop();
			if (sp == 0) return 32'd0;
			sp--;
			return stk[sp];
		endfunction

		function void put_local(int unsigned i, logic [31:0] v);
			loc[i] = v;
			loc_set[i] = 1'b1;
		endfunction

		function bit branch_taken(logic [2:0] kind, logic [31:0] a, logic [31:0] b);
			case (kind)
				COND_EQ: return a == b;
				COND_NE: return a != b;
				COND_LT: return $signed(a) < $signed(b);
				COND_GE: return !($signed(a) < $signed(b));
				COND_GT: return $signed(b) < $signed(a);
				default: return !($signed(b) < $signed(a));
			endcase
		endfunction

		// true when the item would read a local that was never written
		function bit reads_blank(instr_t it);
			int unsigned idx;
			int unsigned n;
			logic [7:0] op;
			op = it.operation;
			idx = wide_hi * 256 + it.immediate[7:0];
			case (op) inside
				OP_ILOAD, OP_FLOAD, OP_ALOAD, OP_IINC, OP_RET:
					return idx < NLOC && !loc_set[idx];
				OP_LLOAD, OP_DLOAD:
					return idx + 1 < NLOC && (!loc_set[idx] || !loc_set[idx + 1]);
				[OP_ILOAD_0:OP_ALOAD_3]: begin
					n = (op - OP_ILOAD_0) & 3;
					if (((op - OP_ILOAD_0) >> 2) % 2 == 1)
						return !loc_set[n] || !loc_set[n + 1];
					return !loc_set[n];
				end
				default: return 1'b0;
			endcase
		endfunction

		function result_t execute(instr_t it);
			logic [7:0] op;
			logic [31:0] imm;
			logic [15:0] pc;
			logic [15:0] target;
			logic [31:0] a;
			logic [31:0] b;
			logic [31:0] c;
			logic [31:0] d;
			logic [31:0] r;
			logic [4:0] sh;
			logic [1:0] st;
			int unsigned idx;
			int unsigned n;
			int unsigned len;
			bit jump;
			longint qa;
			longint qb;
			result_t res;
			op = it.operation;
			imm = it.immediate;
			pc = it.instr_addr;
			idx = wide_hi * 256 + imm[7:0];
			st = ST_OK;
			len = 1;
			jump = 1'b0;
			target = pc + imm[15:0];
			case (op) inside
				OP_NOP: ;
				OP_ACONST_NULL:
					if (fits(0, 1)) push(32'd0); else st = ST_FAULT;
				[OP_ICONST_M1:OP_ICONST_5]:
					if (fits(0, 1)) push(32'(op) - 32'(OP_ICONST_M1) - 1);
					else st = ST_FAULT;
				OP_LCONST_0, OP_LCONST_1:
					if (fits(0, 2)) begin
						push(32'(op - OP_LCONST_0));
						push(32'd0);
					end else st = ST_FAULT;
				OP_BIPUSH: begin
					len = 2;
					if (fits(0, 1)) push({{24{imm[7]}}, imm[7:0]}); else st = ST_FAULT;
				end
				OP_SIPUSH: begin
					len = 3;
					if (fits(0, 1)) push({{16{imm[15]}}, imm[15:0]}); else st = ST_FAULT;
				end
				OP_LDC, OP_LDC_W: begin
					len = (op == OP_LDC) ? 2 : 3;
					if (fits(0, 1)) push(imm); else st = ST_FAULT;
				end
				OP_ILOAD, OP_FLOAD, OP_ALOAD: begin
					len = 2;
					if (idx < NLOC && fits(0, 1)) push(loc[idx]); else st = ST_FAULT;
				end
				OP_LLOAD, OP_DLOAD: begin
					len = 2;
					if (idx + 1 < NLOC && fits(0, 2)) begin
						push(loc[idx]);
						push(loc[idx + 1]);
					end else st = ST_FAULT;
				end
				OP_ISTORE, OP_FSTORE, OP_ASTORE: begin
					len = 2;
					if (idx < NLOC && fits(1, 0)) put_local(idx, pop()); else st = ST_FAULT;
				end
				OP_LSTORE, OP_DSTORE: begin
					len = 2;
					if (idx + 1 < NLOC && fits(2, 0)) begin
						put_local(idx + 1, pop());
						put_local(idx, pop());
					end else st = ST_FAULT;
				end
				[OP_ILOAD_0:OP_ALOAD_3]: begin
					n = (op - OP_ILOAD_0) & 3;
					if (((op - OP_ILOAD_0) >> 2) % 2 == 1) begin
						if (fits(0, 2)) begin
							push(loc[n]);
							push(loc[n + 1]);
						end else st = ST_FAULT;
					end else if (fits(0, 1)) push(loc[n]);
					else st = ST_FAULT;
				end
				[OP_ISTORE_0:OP_ASTORE_3]: begin
					n = (op - OP_ISTORE_0) & 3;
					if (((op - OP_ISTORE_0) >> 2) % 2 == 1) begin
						if (fits(2, 0)) begin
							put_local(n + 1, pop());
							put_local(n, pop());
						end else st = ST_FAULT;
					end else if (fits(1, 0)) put_local(n, pop());
					else st = ST_FAULT;
				end
				OP_POP: if (fits(1, 0)) void'(pop()); else st = ST_FAULT;
				OP_POP2:
					if (fits(2, 0)) begin
						void'(pop());
						void'(pop());
					end else st = ST_FAULT;
				OP_DUP: if (fits(1, 1)) push(peek(0)); else st = ST_FAULT;
				OP_DUP_X1:
					if (fits(2, 1)) begin
						a = peek(0); b = peek(1);
						poke(1, a); poke(0, b); push(a);
					end else st = ST_FAULT;
				OP_DUP_X2:
					if (fits(3, 1)) begin
						a = peek(0); b = peek(1); c = peek(2);
						poke(2, a); poke(1, c); poke(0, b); push(a);
					end else st = ST_FAULT;
				OP_DUP2:
					if (fits(2, 2)) begin
						a = peek(0); b = peek(1);
						push(b); push(a);
					end else st = ST_FAULT;
				OP_DUP2_X1:
					if (fits(3, 2)) begin
						a = peek(0); b = peek(1); c = peek(2);
						poke(2, b); poke(1, a); poke(0, c); push(b); push(a);
					end else st = ST_FAULT;
				OP_DUP2_X2:
					if (fits(4, 2)) begin
						a = peek(0); b = peek(1); c = peek(2); d = peek(3);
						poke(3, b); poke(2, a); poke(1, d); poke(0, c); push(b); push(a);
					end else st = ST_FAULT;
				OP_SWAP:
					if (fits(2, 0)) begin
						a = peek(0);
						poke(0, peek(1));
						poke(1, a);
					end else st = ST_FAULT;
				OP_IADD, OP_ISUB, OP_IMUL, OP_IDIV, OP_IREM, OP_ISHL, OP_ISHR, OP_IUSHR,
				OP_IAND, OP_IOR, OP_IXOR:
					if (!fits(2, 0)) st = ST_FAULT;
					else begin
						b = peek(0);
						a = peek(1);
						sh = b[4:0];
						if ((op == OP_IDIV || op == OP_IREM) && b == 0) st = ST_DIVZ;
						else begin
							qa = $signed(a);
							qb = $signed(b);
							case (op)
								OP_IADD: r = a + b;
								OP_ISUB: r = a - b;
								OP_IMUL: r = a * b;
								OP_IDIV: r = 32'(qa / qb);
								OP_IREM: r = 32'(qa % qb);
								OP_ISHL: r = a << sh;
								OP_ISHR: r = $signed(a) >>> sh;
								OP_IUSHR: r = a >> sh;
								OP_IAND: r = a & b;
								OP_IOR: r = a | b;
								default: r = a ^ b;
							endcase
							void'(pop());
							poke(0, r);
						end
					end
				OP_INEG: if (fits(1, 0)) poke(0, 32'd0 - peek(0)); else st = ST_FAULT;
				OP_LAND, OP_LOR, OP_LXOR:
					if (fits(4, 0)) begin
						a = peek(0); b = peek(1);
						if (op == OP_LAND) begin
							poke(2, peek(2) & a); poke(3, peek(3) & b);
						end else if (op == OP_LOR) begin
							poke(2, peek(2) | a); poke(3, peek(3) | b);
						end else begin
							poke(2, peek(2) ^ a); poke(3, peek(3) ^ b);
						end
						void'(pop());
						void'(pop());
					end else st = ST_FAULT;
				OP_IINC: begin
					len = 3;
					if (idx < NLOC)
						put_local(idx, loc[idx] + {{24{it.increment[7]}}, it.increment});
					else st = ST_FAULT;
				end
				OP_I2L:
					if (fits(1, 1)) begin
						a = peek(0);
						push(a[31] ? 32'hffffffff : 32'd0);
					end else st = ST_FAULT;
				OP_L2I: if (fits(2, 0)) void'(pop()); else st = ST_FAULT;
				OP_I2B:
					if (fits(1, 0)) begin
						a = peek(0);
						poke(0, {{24{a[7]}}, a[7:0]});
					end else st = ST_FAULT;
				OP_I2C: if (fits(1, 0)) poke(0, peek(0) & 32'h0000ffff); else st = ST_FAULT;
				OP_I2S:
					if (fits(1, 0)) begin
						a = peek(0);
						poke(0, {{16{a[15]}}, a[15:0]});
					end else st = ST_FAULT;
				[OP_IFEQ:OP_IFLE]: begin
					len = 3;
					if (fits(1, 0)) jump = branch_taken(3'(op - OP_IFEQ), pop(), 32'd0);
					else st = ST_FAULT;
				end
				[OP_IF_ICMPEQ:OP_IF_ACMPNE]: begin
					len = 3;
					if (fits(2, 0)) begin
						b = pop();
						a = pop();
						jump = branch_taken(op <= OP_IF_ICMPLE ? 3'(op - OP_IF_ICMPEQ)
							: 3'(op - OP_IF_ACMPEQ), a, b);
					end else st = ST_FAULT;
				end
				OP_IFNULL, OP_IFNONNULL: begin
					len = 3;
					if (fits(1, 0)) begin
						a = pop();
						jump = (op == OP_IFNULL) ? (a == 0) : (a != 0);
					end else st = ST_FAULT;
				end
				OP_GOTO, OP_GOTO_W: begin
					len = (op == OP_GOTO) ? 3 : 5;
					jump = 1'b1;
				end
				OP_JSR, OP_JSR_W: begin
					len = (op == OP_JSR) ? 3 : 5;
					if (fits(0, 1)) begin
						push(32'(16'(pc + len)));
						jump = 1'b1;
					end else st = ST_FAULT;
				end
				OP_RET: begin
					len = 2;
					if (idx < NLOC) begin
						jump = 1'b1;
						target = loc[idx][15:0];
					end else st = ST_FAULT;
				end
				OP_WIDE: begin
					len = 2;
					wide_hi = imm[7:0];
				end
				default: st = ST_UNSUP;
			endcase
			if (st == ST_OK && op != OP_WIDE) wide_hi = 0;
			res.next_addr = (st != ST_OK) ? pc : (jump ? target : 16'(pc + len));
			res.top_value = (sp != 0) ? stk[sp - 1] : 32'd0;
			res.depth = DEPTH_W'(sp);
			res.status = st;
			return res;
		endfunction

		function void note_request(instr_t it);
			result_t res;
			res = execute(it);
			pending.push_back(res);
			st_count[res.status]++;
			requests++;
		endfunction

		function void check_result(result_t got);
			result_t want;
			results++;
			if (pending.size() == 0) begin
				$error("result with no request pending: %p", got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.next_addr !== want.next_addr) begin
				$error("next_addr: expected %h, got %h", want.next_addr, got.next_addr);
				errors++;
			end
			if (got.top_value !== want.top_value) begin
				$error("top_value: expected %h, got %h", want.top_value, got.top_value);
				errors++;
			end
			if (got.depth !== want.depth) begin
				$error("depth: expected %0d, got %0d", want.depth, got.depth);
				errors++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
		endfunction
	endclass

	localparam logic [7:0] STACK_OPS[29] = '{OP_IADD, OP_ISUB, OP_IMUL, OP_IDIV, OP_IREM,
		OP_INEG, OP_ISHL, OP_ISHR, OP_IUSHR, OP_IAND, OP_IOR, OP_IXOR, OP_LAND, OP_LOR,
		OP_LXOR, OP_I2L, OP_L2I, OP_I2B, OP_I2C, OP_I2S, OP_POP, OP_POP2, OP_DUP, OP_DUP_X1,
		OP_DUP_X2, OP_DUP2, OP_DUP2_X1, OP_DUP2_X2, OP_SWAP};
	localparam logic [7:0] STORE_OPS[5] = '{OP_ISTORE, OP_LSTORE, OP_FSTORE, OP_DSTORE,
		OP_ASTORE};
	localparam logic [7:0] LOAD_OPS[5] = '{OP_ILOAD, OP_LLOAD, OP_FLOAD, OP_DLOAD, OP_ALOAD};
	localparam logic [7:0] JUMP_OPS[6] = '{OP_IFNULL, OP_IFNONNULL, OP_GOTO, OP_GOTO_W,
		OP_JSR, OP_JSR_W};

	logic clk;
	logic arst_n;
	longint cycles;
	bit no_idle;
	bytecode_scoreboard sb;

	bci_in_if instr_ch();
	bci_out_if result_ch();

	stack_bytecode_integer_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.instr(instr_ch),
		.result(result_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Verification failed");
			$finish;
		end
	end

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 7))
			0: return 32'd0;
			1: return 32'hffffffff;
			2: return 32'h80000000;
			3: return 32'h7fffffff;
			4: return 32'($urandom_range(0, 40)) - 32'd20;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] rand_index();
		return ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 15));
	endfunction

	function automatic instr_t make_item();
		instr_t it;
		int unsigned pick;
		it.immediate = rand_word();
		it.increment = 8'($urandom);
		it.instr_addr = 16'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 25) begin
			case ($urandom_range(0, 5))
				0: it.operation = 8'(OP_ACONST_NULL + $urandom_range(0, 7));
				1: it.operation = 8'(OP_LCONST_0 + $urandom_range(0, 1));
				2: it.operation = OP_BIPUSH;
				3: it.operation = OP_SIPUSH;
				default: it.operation = 8'(OP_LDC + $urandom_range(0, 1));
			endcase
			if (sb.sp > 48) it.operation = OP_POP2;
		end else if (pick < 40) begin
			it.immediate = rand_index();
			it.operation = ($urandom_range(0, 2) == 0)
				? 8'(OP_ISTORE_0 + $urandom_range(0, 19)) : STORE_OPS[$urandom_range(0, 4)];
		end else if (pick < 52) begin
			it.immediate = rand_index();
			it.operation = ($urandom_range(0, 2) == 0)
				? 8'(OP_ILOAD_0 + $urandom_range(0, 19)) : LOAD_OPS[$urandom_range(0, 4)];
		end else if (pick < 74) begin
			it.operation = STACK_OPS[$urandom_range(0, 28)];
		end else if (pick < 86) begin
			case ($urandom_range(0, 3))
				0: it.operation = 8'(OP_IFEQ + $urandom_range(0, 5));
				1: it.operation = 8'(OP_IF_ICMPEQ + $urandom_range(0, 7));
				2: it.operation = JUMP_OPS[$urandom_range(0, 5)];
				default: begin
					it.operation = OP_RET;
					it.immediate = rand_index();
				end
			endcase
		end else if (pick < 90) begin
			it.operation = OP_WIDE;
			it.immediate = ($urandom_range(0, 2) == 0) ? $urandom : 32'd0;
		end else if (pick < 95) begin
			it.operation = OP_IINC;
			it.immediate = rand_index();
		end else begin
			it.operation = 8'($urandom);
		end
		return it;
	endfunction

	function automatic instr_t mk(logic [7:0] op, logic [31:0] imm, logic [15:0] pc,
			logic [7:0] incr);
		instr_t it;
		it.operation = op;
		it.immediate = imm;
		it.increment = incr;
		it.instr_addr = pc;
		return it;
	endfunction

	// ready only moves at the rising edge, so its value just before the edge is what the edge sees
	task automatic send(instr_t it);
		int unsigned gap;
		bit taken;
		if (sb.reads_blank(it)) it.operation = OP_NOP;
		gap = no_idle ? 0 : $urandom_range(0, 12);
		if (gap > 0) begin
			instr_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		instr_ch.data = it;
		instr_ch.valid = 1'b1;
		do begin
			taken = instr_ch.ready;
			@(posedge clk);
		end while (!taken);
		sb.note_request(it);
		@(negedge clk);
	endtask

	task automatic drain();
		instr_ch.valid = 1'b0;
		while (sb.pending.size() != 0) @(negedge clk);
	endtask

	initial begin
		int unsigned gap;
		bit taken;
		result_t got;
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = no_idle ? 0 : $urandom_range(0, 12);
			if (gap > 0) begin
				result_ch.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			result_ch.ready = 1'b1;
			do begin
				taken = result_ch.valid;
				got = result_ch.data;
				@(posedge clk);
			end while (!taken);
			sb.check_result(got);
			@(negedge clk);
		end
	end

	initial begin
		sb = new();
		cycles = 0;
		no_idle = 1'b0;
		arst_n = 1'b0;
		instr_ch.valid = 1'b0;
		instr_ch.data = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send(mk(OP_POP, 0, 16'h0000, 0));
		send(mk(OP_LDC, 32'h80000000, 16'h0010, 0));
		send(mk(OP_ICONST_M1, 0, 16'h0012, 0));
		send(mk(OP_IDIV, 0, 16'h0013, 0));
		send(mk(OP_ICONST_M1, 0, 16'h0014, 0));
		send(mk(OP_IREM, 0, 16'h0015, 0));
		send(mk(8'(OP_ICONST_M1 + 1), 0, 16'h0016, 0));
		send(mk(OP_IDIV, 0, 16'h0017, 0));
		send(mk(OP_POP2, 0, 16'h0018, 0));
		send(mk(OP_BIPUSH, 32'h00000080, 16'h0019, 0));
		send(mk(OP_SIPUSH, 32'hffff8000, 16'h001b, 0));
		send(mk(OP_LCONST_1, 0, 16'h001e, 0));
		send(mk(OP_LSTORE, 32'd254, 16'h001f, 0));
		send(mk(OP_WIDE, 32'd0, 16'h0021, 0));
		send(mk(OP_LLOAD, 32'd255, 16'h0023, 0));
		send(mk(OP_WIDE, 32'hffffff01, 16'h0025, 0));
		send(mk(OP_ILOAD, 32'd0, 16'h0027, 0));
		send(mk(OP_IINC, 32'd254, 16'h0029, 8'h80));
		send(mk(OP_NOP, 0, 16'h002c, 0));
		send(mk(OP_IINC, 32'd254, 16'h002d, 8'h7f));
		send(mk(OP_RET, 32'd254, 16'h0030, 0));
		send(mk(OP_JSR_W, 32'd5, 16'hfffe, 0));
		send(mk(OP_IF_ACMPNE, 32'hfffffff0, 16'h7fff, 0));
		send(mk(OP_LXOR, 0, 16'h0040, 0));
		send(mk(OP_UNSUP, 32'hffffffff, 16'hffff, 8'hff));

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 150 == 0) no_idle = ($urandom_range(0, 2) == 0);
			if (i == RANDOM_ITEMS / 2) begin
				drain();
				@(negedge clk);
			end
			send(make_item());
		end

		no_idle = 1'b1;
		while (NSTK - sb.sp >= 2)
			send(mk((sb.sp >= 2) ? OP_DUP2 : OP_LCONST_1, 0, 16'($urandom), 0));
		if (sb.sp < NSTK) send(mk(8'(OP_ICONST_M1 + 3), 0, 16'($urandom), 0));
		send(mk(OP_BIPUSH, $urandom, 16'($urandom), 0));
		send(mk(OP_DUP, 0, 16'($urandom), 0));
		send(mk(OP_POP, 0, 16'($urandom), 0));
		send(mk(OP_LCONST_0, 0, 16'($urandom), 0));
		send(mk(OP_JSR, 32'd6, 16'($urandom), 0));
		no_idle = 1'b0;

		drain();
		repeat (60) @(posedge clk);
		$display("%0d requests, %0d results; status ok %0d, unsupported %0d, fault %0d, div0 %0d",
			sb.requests, sb.results, sb.st_count[ST_OK], sb.st_count[ST_UNSUP],
			sb.st_count[ST_FAULT], sb.st_count[ST_DIVZ]);
		$display("covered directed corner cases, random bytecode streams and a full-stack fill");
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
